@@ rtl/core/lbm_pkg.sv @@
// Shared types, constants and colour codes for the LED bar meter with peak hold.
// No dependencies; every module of the block imports this package.
`default_nettype none

package lbm_pkg;

	// Bar geometry and peak-marker timing
	localparam int unsigned MAX_LEDS       = 64;
	localparam int unsigned PAUSE_FRAMES   = 16;
	localparam int unsigned FALLING_FRAMES = 4;

	localparam int unsigned LED_W   = 6;   // LED position / lit count
	localparam int unsigned LEN_W   = 7;   // configured bar length
	localparam int unsigned PHASE_W = 8;   // peak phase counter, wraps

	localparam logic [PHASE_W-1:0] PAUSE_CNT    = PHASE_W'(PAUSE_FRAMES);
	localparam logic [PHASE_W-1:0] FALL_CNT     = PHASE_W'(FALLING_FRAMES);
	localparam logic [PHASE_W-1:0] FALL_CNT_M1  = PHASE_W'(FALLING_FRAMES - 1);
	localparam logic [LEN_W-1:0]   MIN_LEN      = LEN_W'(2);
	localparam logic [LEN_W-1:0]   MAX_LEN      = LEN_W'(MAX_LEDS);
	localparam logic [LED_W-1:0]   MAX_LEN_M1   = LED_W'(MAX_LEDS - 1);

	// Configuration register indexes
	localparam logic [1:0] CFG_LEDS    = 2'd0;
	localparam logic [1:0] CFG_MIDDLE  = 2'd1;
	localparam logic [1:0] CFG_REVERSE = 2'd2;

	// Colour classes
	typedef enum logic [2:0] {
		COL_BACKGROUND = 3'd0,
		COL_FIRST      = 3'd1,
		COL_SECOND     = 3'd2,
		COL_LOW        = 3'd3,
		COL_MIDDLE     = 3'd4,
		COL_PEAK       = 3'd5
	} color_t;

	// Decoded configuration
	typedef struct packed {
		logic [LED_W-1:0] len_m1;     // clamped bar length minus one
		logic [LEN_W-1:0] mid_start;
		logic             reverse;
	} cfg_t;

	// Per-frame snapshot handed to the LED emitter
	typedef struct packed {
		logic [LED_W-1:0] lit;
		logic [LED_W-1:0] peak;
		logic             hit;
	} frame_t;

endpackage

`default_nettype wire

@@ rtl/core/lbm_cfg.sv @@
// Configuration registers of the LED bar meter and bar-length clamping.
// Depends on lbm_pkg.
`default_nettype none

module lbm_cfg (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              wr_en,
	input  wire logic [1:0]        wr_index,
	input  wire logic [6:0]        wr_data,
	output lbm_pkg::cfg_t          cfg
);
	import lbm_pkg::*;

	logic [LEN_W-1:0] leds_q;
	logic [LEN_W-1:0] mid_q;
	logic             rev_q;

	// Register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			leds_q <= LEN_W'(16);
			mid_q  <= LEN_W'(10);
			rev_q  <= 1'b0;
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_LEDS:    leds_q <= wr_data;
				CFG_MIDDLE:  mid_q  <= wr_data;
				CFG_REVERSE: rev_q  <= wr_data[0];
				default: ;
			endcase
		end
	end

	// Clamp the bar length to 2..MAX_LEDS
	always_comb begin
		priority if (leds_q < MIN_LEN)
			cfg.len_m1 = LED_W'(1);
		else if (leds_q > MAX_LEN)
			cfg.len_m1 = MAX_LEN_M1;
		else
			cfg.len_m1 = LED_W'(leds_q - LEN_W'(1));
		cfg.mid_start = mid_q;
		cfg.reverse   = rev_q;
	end

endmodule

`default_nettype wire

@@ rtl/core/lbm_frame.sv @@
// Per-frame state update: target latch, bar movement and peak-hold timing.
// Holds one finished frame snapshot for the emitter. Depends on lbm_pkg.
`default_nettype none

module lbm_frame (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire lbm_pkg::cfg_t             cfg,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic [lbm_pkg::LED_W-1:0] target_level,
	input  wire logic                      new_target,
	output logic                           snap_valid,
	output lbm_pkg::frame_t                snap,
	input  wire logic                      snap_take
);
	import lbm_pkg::*;

	logic [LED_W-1:0]   lit_q, tgt_q, peak_q;
	logic               rising_q, pfall_q;
	logic [PHASE_W-1:0] phase_q;
	logic               snap_valid_q;
	frame_t             snap_q;

	logic [LED_W-1:0]   t_sat, tgt_n, lit_n, peak_n;
	logic               rising_n, pfall_n;
	logic [PHASE_W-1:0] phase_n, phase_inc;
	logic               accept;

	assign in_ready   = !snap_valid_q || snap_take;
	assign accept     = in_valid && in_ready;
	assign snap_valid = snap_valid_q;
	assign snap       = snap_q;

	// Next frame state
	always_comb begin
		t_sat     = (target_level > cfg.len_m1) ? cfg.len_m1 : target_level;
		tgt_n     = new_target ? t_sat : tgt_q;
		rising_n  = new_target ? (lit_q <= t_sat) : rising_q;

		lit_n = lit_q;
		if (rising_n && lit_q < tgt_n)
			lit_n = lit_q + LED_W'(1);
		else if (!rising_n && lit_q > tgt_n)
			lit_n = lit_q - LED_W'(1);

		peak_n    = peak_q;
		pfall_n   = pfall_q;
		phase_inc = phase_q + PHASE_W'(1);
		phase_n   = phase_q;
		if (peak_q >= lit_n) begin
			// bar below the marker: hold, then fall
			phase_n = phase_inc;
			if (!pfall_q && phase_inc == PAUSE_CNT) begin
				pfall_n = 1'b1;
				phase_n = FALL_CNT_M1;
			end else if (pfall_q && phase_inc == FALL_CNT) begin
				if (peak_q > lit_n)
					peak_n = peak_q - LED_W'(1);
				phase_n = '0;
			end
		end else if (rising_n) begin
			// bar pushes the marker up
			peak_n = lit_n;
			if (pfall_q) begin
				pfall_n = 1'b0;
				phase_n = '0;
			end
		end
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lit_q    <= '0;
			tgt_q    <= '0;
			rising_q <= 1'b1;
			peak_q   <= LED_W'(1);
			pfall_q  <= 1'b1;
			phase_q  <= FALL_CNT_M1;
		end else if (accept) begin
			lit_q    <= lit_n;
			tgt_q    <= tgt_n;
			rising_q <= rising_n;
			peak_q   <= peak_n;
			pfall_q  <= pfall_n;
			phase_q  <= phase_n;
		end
	end

	// Snapshot register toward the emitter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			snap_valid_q <= 1'b0;
		else if (accept)
			snap_valid_q <= 1'b1;
		else if (snap_take)
			snap_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			snap_q.lit  <= lit_n;
			snap_q.peak <= peak_n;
			snap_q.hit  <= (lit_n == tgt_n);
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/lbm_emit.sv @@
// LED emitter: walks one frame's bar, one LED per cycle unless stalled, into the output register.
// Depends on lbm_pkg.
`default_nettype none

module lbm_emit (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire lbm_pkg::cfg_t             cfg,
	input  wire logic                      snap_valid,
	input  wire lbm_pkg::frame_t           snap,
	output logic                           snap_take,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic [lbm_pkg::LED_W-1:0]      led_index,
	output logic [2:0]                     color_class,
	output logic                           last_led,
	output logic                           at_target
);
	import lbm_pkg::*;

	logic             act_q;
	logic [LED_W-1:0] k_q;
	frame_t           frm_q;

	logic             out_valid_q, last_q, hit_q;
	logic [LED_W-1:0] led_q;
	color_t           color_q;

	logic             adv, is_last;
	logic [LED_W-1:0] led;
	color_t           color;

	assign adv       = act_q && (!out_valid_q || out_ready);
	assign is_last   = (k_q == cfg.len_m1);
	assign snap_take = snap_valid && (!act_q || (adv && is_last));

	// Position and colour of the current LED
	always_comb begin
		led = cfg.reverse ? (cfg.len_m1 - k_q) : k_q;
		priority if (led == frm_q.peak)
			color = COL_PEAK;
		else if (led >= frm_q.lit)
			color = COL_BACKGROUND;
		else if (led == LED_W'(0))
			color = COL_FIRST;
		else if (led == LED_W'(1))
			color = COL_SECOND;
		else if (LEN_W'(led) < cfg.mid_start)
			color = COL_LOW;
		else
			color = COL_MIDDLE;
	end

	// Frame walk control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
			k_q   <= '0;
		end else if (snap_take) begin
			act_q <= 1'b1;
			k_q   <= '0;
		end else if (adv && is_last) begin
			act_q <= 1'b0;
		end else if (adv) begin
			k_q <= k_q + LED_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (snap_take)
			frm_q <= snap;
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (adv)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			led_q   <= led;
			color_q <= color;
			last_q  <= is_last;
			hit_q   <= frm_q.hit;
		end
	end

	assign out_valid   = out_valid_q;
	assign led_index   = led_q;
	assign color_class = color_q;
	assign last_led    = last_q;
	assign at_target   = hit_q;

endmodule

`default_nettype wire

@@ rtl/core/led_bar_meter_peak_hold.sv @@
// Top level of one LED bar meter channel with falling peak-hold marker.
// Instantiates lbm_cfg, lbm_frame and lbm_emit; depends on lbm_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready, target_level, new_target): one transaction is
//   one animation frame. new_target latches a new target; the bar then moves one
//   LED toward it and the peak marker is held or falls.
//   Output channel (out_valid/out_ready, led_index, color_class, last_led,
//   at_target): one transaction per LED of the bar, in bar order or reversed;
//   last_led marks the final LED of a frame.
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): always ready;
//   index 0 bar length, 1 middle-zone start, 2 reverse order. Write only while idle.
// Timing:
//   The first LED of a frame passes the snapshot register, the emitter's frame
//   register and the output register. The emitter issues one LED per cycle unless
//   out_ready stalls it; a frame holds the emitter for its clamped bar length (2..64) in LEDs.
//   The next frame is accepted while the current one is still being emitted.
// Reset: bar empty, target 0, peak marker at LED 1 in its falling phase.
// Stall: with out_ready low the output register holds; the emitter and then the
//   frame snapshot back up and in_ready drops. No LED is lost or repeated.
`default_nettype none

module led_bar_meter_peak_hold (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [6:0]  cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [5:0]  target_level,
	input  wire logic        new_target,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [5:0]       led_index,
	output logic [2:0]       color_class,
	output logic             last_led,
	output logic             at_target
);
	import lbm_pkg::*;

	cfg_t   cfg;
	frame_t snap;
	logic   snap_valid, snap_take;

	assign cfg_ready = 1'b1;

	lbm_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	lbm_frame u_frame (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.target_level (target_level),
		.new_target   (new_target),
		.snap_valid   (snap_valid),
		.snap         (snap),
		.snap_take    (snap_take)
	);

	lbm_emit u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.snap_valid  (snap_valid),
		.snap        (snap),
		.snap_take   (snap_take),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.led_index   (led_index),
		.color_class (color_class),
		.last_led    (last_led),
		.at_target   (at_target)
	);

	// An empty snapshot slot always takes a new frame
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!snap_valid |-> in_ready)
		else $error("in_ready low with empty frame slot");

	// An accepted frame lands in the snapshot slot
	a_frame_captured: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> snap_valid)
		else $error("accepted frame not captured");

	// at_target is constant across the LEDs of one frame
	a_hit_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !last_led) |=> (!out_valid || at_target == $past(at_target)))
		else $error("at_target changed within a frame");

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for led_bar_meter_peak_hold: frames go in, one LED word per LED
// comes out and is compared with a bar / peak-marker predictor kept in the bench.
// Depends on lbm_pkg and the RTL of led_bar_meter_peak_hold.

module testbench;
	import lbm_pkg::*;

	localparam int HALF_PERIOD  = 4;
	localparam int RESET_CYCLES = 6;
	localparam int CYCLE_LIMIT  = 2_000_000;
	localparam int HOLD_CYCLES  = 600;
	localparam int HOLD_AFTER   = 150;
	localparam int DRAIN_CYCLES = 16;
	localparam int MAX_GAP      = 14;
	localparam int RAND_PHASES  = 8;
	localparam int PHASE_FRAMES = 48;
	localparam int PRINT_CAP    = 40;

	// unmapped register index, writes to it must be ignored
	localparam logic [1:0] CFG_SPARE = 2'd3;

	typedef struct packed {
		logic [LED_W-1:0] pos;
		color_t           colour;
		logic             last;
		logic             hit;
	} led_word_t;

	typedef struct {
		logic [LED_W-1:0] level;
		logic             latch;
		int unsigned      idle;
	} frame_req_t;

	// DUT signals
	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [1:0]       cfg_index = CFG_LEDS;
	logic [6:0]       cfg_data = '0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	logic [5:0]       target_level = '0;
	logic             new_target = 1'b0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic [5:0]       led_index;
	logic [2:0]       color_class;
	logic             last_led;
	logic             at_target;

	// stimulus and scoreboard
	frame_req_t       frame_pending[$];
	led_word_t        led_expect[$];
	int unsigned      idle_cnt = 0;
	int unsigned      stall_left = 0;
	int unsigned      hold_left = 0;
	logic             hold_done = 1'b0;
	logic             tx_quiet = 1'b0;
	logic             rx_quiet = 1'b0;
	int unsigned      frames_taken = 0;
	int unsigned      leds_seen = 0;
	int unsigned      reg_writes = 0;
	int unsigned      err_count = 0;
	int unsigned      cycle_cnt = 0;

	// predictor copy of configuration and meter state
	logic [LEN_W-1:0]   m_len_cfg = 7'd16;
	logic [LEN_W-1:0]   m_mid = 7'd10;
	logic               m_rev = 1'b0;
	logic [LED_W-1:0]   m_lit = '0;
	logic [LED_W-1:0]   m_target = '0;
	logic               m_rising = 1'b1;
	logic [LED_W-1:0]   m_peak = 6'd1;
	logic               m_falling = 1'b1;
	logic [PHASE_W-1:0] m_phase = FALL_CNT_M1;

	led_bar_meter_peak_hold u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.target_level (target_level),
		.new_target   (new_target),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.led_index    (led_index),
		.color_class  (color_class),
		.last_led     (last_led),
		.at_target    (at_target)
	);

	always #HALF_PERIOD clk = ~clk;

	// colour of one LED from the current bar and peak
	function automatic color_t led_colour(input int unsigned led);
		if (led == m_peak) return COL_PEAK;
		if (led >= m_lit) return COL_BACKGROUND;
		if (led == 0) return COL_FIRST;
		if (led == 1) return COL_SECOND;
		if (led < m_mid) return COL_LOW;
		return COL_MIDDLE;
	endfunction

	// advance the meter by one frame and queue the LED words it produces
	task automatic predict_frame(input logic [LED_W-1:0] level, input logic latch);
		int unsigned n, t, k, led;
		led_word_t w;
		n = m_len_cfg;
		if (n < MIN_LEN) n = MIN_LEN;
		if (n > MAX_LEN) n = MAX_LEN;
		// latch target, saturated to the bar
		if (latch) begin
			t = level;
			if (t > n - 1) t = n - 1;
			m_target = LED_W'(t);
			m_rising = (m_lit <= m_target);
		end
		// one step toward the target
		if (m_rising && m_lit < m_target) m_lit = m_lit + 1'b1;
		else if (!m_rising && m_lit > m_target) m_lit = m_lit - 1'b1;
		// peak marker: hold, then fall one LED per falling period
		if (m_peak >= m_lit) begin
			m_phase = m_phase + 1'b1;
			if (!m_falling && m_phase == PAUSE_CNT) begin
				m_falling = 1'b1;
				m_phase = FALL_CNT_M1;
			end else if (m_falling && m_phase == FALL_CNT) begin
				if (m_peak > m_lit) m_peak = m_peak - 1'b1;
				m_phase = '0;
			end
		end else if (m_rising) begin
			m_peak = m_lit;
			if (m_falling) begin
				m_falling = 1'b0;
				m_phase = '0;
			end
		end
		// one word per LED, in bar order or reversed
		for (k = 0; k < n; k++) begin
			led = m_rev ? (n - 1 - k) : k;
			w.pos = LED_W'(led);
			w.colour = led_colour(led);
			w.last = (k == n - 1);
			w.hit = (m_lit == m_target);
			led_expect.push_back(w);
		end
	endtask

	task automatic report_mismatch(input string what, input logic [7:0] got,
			input logic [7:0] want);
		err_count++;
		if (err_count <= PRINT_CAP)
			$display("LED word %0d: %s is %0d, expected %0d", leds_seen, what, got, want);
	endtask

	// frame driver: pops pending frames, honors per-frame idle gaps
	always @(posedge clk or negedge arst_n) begin : frame_driver
		frame_req_t req;
		logic offer;
		int unsigned waited;
		if (!arst_n) begin
			in_valid <= 1'b0;
			target_level <= '0;
			new_target <= 1'b0;
			idle_cnt <= 0;
		end else begin
			offer = in_valid;
			waited = idle_cnt;
			if (in_valid && in_ready) begin
				predict_frame(target_level, new_target);
				frames_taken <= frames_taken + 1;
				offer = 1'b0;
			end
			if (!offer && frame_pending.size() != 0) begin
				if (waited >= frame_pending[0].idle) begin
					req = frame_pending.pop_front();
					target_level <= req.level;
					new_target <= req.latch;
					offer = 1'b1;
					waited = 0;
				end else begin
					waited++;
				end
			end
			in_valid <= offer;
			idle_cnt <= waited;
		end
	end

	// long receiver hold-off, once, while frames keep coming
	always @(posedge clk or negedge arst_n) begin : rx_hold
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (!hold_done && frames_taken >= HOLD_AFTER) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end
	end

	// LED monitor: checks each transaction against the oldest expected word
	always @(posedge clk or negedge arst_n) begin : led_monitor
		led_word_t want;
		int unsigned stall;
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left <= 0;
		end else begin
			stall = stall_left;
			if (out_valid && out_ready) begin
				if (led_expect.size() == 0) begin
					report_mismatch("unexpected word, led_index", led_index, 8'd0);
				end else begin
					want = led_expect.pop_front();
					if (led_index !== want.pos)
						report_mismatch("led_index", led_index, want.pos);
					if (color_class !== want.colour)
						report_mismatch("color_class", color_class, want.colour);
					if (last_led !== want.last)
						report_mismatch("last_led", last_led, want.last);
					if (at_target !== want.hit)
						report_mismatch("at_target", at_target, want.hit);
				end
				leds_seen <= leds_seen + 1;
				stall = rx_quiet ? 0 : $urandom_range(0, MAX_GAP);
			end else if (stall != 0) begin
				stall--;
			end
			stall_left <= stall;
			out_ready <= (stall == 0) && (hold_left == 0);
		end
	end

	// timeout
	always @(posedge clk) begin : watchdog
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words still expected", cycle_cnt,
				led_expect.size());
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic add_frame(input logic [LED_W-1:0] level, input logic latch);
		frame_req_t req;
		req.level = level;
		req.latch = latch;
		req.idle = tx_quiet ? 0 : $urandom_range(0, MAX_GAP);
		frame_pending.push_back(req);
	endtask

	// wait until every frame is in and every LED word is out, then let the pipe drain;
	// sampled on the falling edge so that the driver's updates have settled
	task automatic settle;
		do @(negedge clk);
		while (frame_pending.size() != 0 || in_valid || led_expect.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// register write; only called while the block is idle
	task automatic write_reg(input logic [1:0] idx, input logic [6:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_LEDS: begin
				m_len_cfg = val;
			end
			CFG_MIDDLE: begin
				m_mid = val;
			end
			CFG_REVERSE: begin
				m_rev = val[0];
			end
			default: begin
			end
		endcase
		reg_writes++;
	endtask

	// random setting, mostly short bars, sometimes out of range
	task automatic pick_setting(output int unsigned n);
		logic [6:0] len_val, mid_val;
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r < 6) len_val = 7'($urandom_range(2, 16));
		else if (r < 8) len_val = 7'($urandom_range(17, 40));
		else if (r == 8) len_val = 7'($urandom_range(41, 64));
		else if ($urandom_range(0, 1) != 0) len_val = 7'($urandom_range(65, 127));
		else len_val = 7'($urandom_range(0, 1));
		n = len_val;
		if (n < MIN_LEN) n = MIN_LEN;
		if (n > MAX_LEN) n = MAX_LEN;
		if ($urandom_range(0, 3) != 0) mid_val = 7'($urandom_range(0, n + 2));
		else mid_val = 7'($urandom_range(0, 127));
		write_reg(CFG_LEDS, len_val);
		write_reg(CFG_MIDDLE, mid_val);
		write_reg(CFG_REVERSE, 7'($urandom_range(0, 127)));
	endtask

	// mostly a new target followed by a run of plain frames, some noise frames
	task automatic queue_frames(input int unsigned count, input int unsigned n);
		int unsigned left, run;
		left = count;
		while (left != 0) begin
			if ($urandom_range(0, 6) == 0) begin
				add_frame(LED_W'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
				left--;
			end else begin
				if ($urandom_range(0, 3) != 0)
					add_frame(LED_W'($urandom_range(0, n - 1)), 1'b1);
				else
					add_frame(LED_W'($urandom_range(0, 63)), 1'b1);
				left--;
				run = $urandom_range(0, 36);
				while (run != 0 && left != 0) begin
					add_frame(LED_W'($urandom_range(0, 63)), 1'b0);
					run--;
					left--;
				end
			end
		end
	endtask

	initial begin : stimulus
		int unsigned p, n;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// reset setting: target beyond the bar saturates, then the bar falls back toward empty
		add_frame(6'd63, 1'b1);
		add_frame(6'd63, 1'b0);
		add_frame(6'd42, 1'b0);
		add_frame(6'd21, 1'b0);
		add_frame(6'd0, 1'b1);
		add_frame(6'd0, 1'b0);
		add_frame(6'd63, 1'b0);
		settle;

		// length above range clamps to full bar, no middle zone, reversed
		write_reg(CFG_LEDS, 7'd127);
		write_reg(CFG_MIDDLE, 7'd127);
		write_reg(CFG_REVERSE, 7'h41);
		add_frame(6'd63, 1'b1);
		repeat (4) add_frame(LED_W'($urandom_range(0, 63)), 1'b0);
		settle;

		// shrink bar below the lit LEDs: lit count and peak now lie past the end
		write_reg(CFG_LEDS, 7'd0);
		write_reg(CFG_MIDDLE, 7'd0);
		write_reg(CFG_REVERSE, 7'h7E);
		add_frame(6'd1, 1'b1);
		add_frame(6'd0, 1'b0);
		add_frame(6'd0, 1'b0);
		settle;

		// minimum length, middle zone start past the bar, reversed; spare index ignored
		write_reg(CFG_LEDS, 7'd1);
		write_reg(CFG_MIDDLE, 7'd64);
		write_reg(CFG_REVERSE, 7'd1);
		write_reg(CFG_SPARE, 7'h55);
		add_frame(6'd63, 1'b1);
		add_frame(6'd0, 1'b0);
		add_frame(6'd0, 1'b0);
		settle;

		// random phases, each with its own setting and idling mode
		for (p = 0; p < RAND_PHASES; p++) begin
			tx_quiet = (p % 4 == 1) || (p % 4 == 3);
			rx_quiet <= (p % 4 >= 2);
			pick_setting(n);
			queue_frames(PHASE_FRAMES, n);
			settle;
		end

		$display("checked %0d frames, %0d LED words, %0d register writes", frames_taken,
			leds_seen, reg_writes);
		$display("bar lengths clamped low to full, both orders, one %0d-cycle output hold-off",
			HOLD_CYCLES);
		if (err_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("%0d mismatches", err_count);
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
